/* src/bptm_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer pool tag manager package
// Field widths, request function codes, the lookup item carried along the
// cell row, and the commit item sent back to every cell.
// ----------------------------------------------------------------------------
package bptm_pkg;

	localparam int FILE_W  = 16;
	localparam int BLOCK_W = 24;
	localparam int USES_W  = 16;
	localparam int SLOT_W  = 4;   // width of the slot field in a result
	// Slot indexes and install ranks are sized for the largest pool (256 slots).
	localparam int IDX_W   = 8;
	localparam int CUT_W   = IDX_W + 1;

	localparam int IN_DATA_W  = FILE_W + BLOCK_W;
	localparam int OUT_DATA_W = 48;

	// Request functions carried in s_tuser.
	localparam logic FUNC_GET   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Lookup item; every cell folds its own slot into it and passes it on.
	typedef struct packed {
		logic               valid;
		logic               func;
		logic [FILE_W-1:0]  file;
		logic [BLOCK_W-1:0] block;
		logic               m_found;  // newest matching tag so far
		logic [IDX_W-1:0]   m_idx;
		logic [IDX_W-1:0]   m_rank;
		logic               f_found;  // lowest free slot so far
		logic [IDX_W-1:0]   f_idx;
		logic               v_found;  // replacement candidate so far
		logic [IDX_W-1:0]   v_idx;
		logic [IDX_W-1:0]   v_rank;
		logic [USES_W-1:0]  v_uses;
		logic [FILE_W-1:0]  v_file;
		logic [BLOCK_W-1:0] v_block;
	} tok_t;

	// Decision broadcast to all cells in the cycle the lookup leaves the row.
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic               func;
		logic [IDX_W-1:0]   idx;
		logic [CUT_W-1:0]   cut;
		logic [FILE_W-1:0]  file;
		logic [BLOCK_W-1:0] block;
	} cmt_t;

endpackage

/* src/bptm_cell.sv */
// ----------------------------------------------------------------------------
// Buffer pool tag manager slot cell
// Holds one slot's tag, use count and install rank, folds them into the
// passing lookup item and applies the commit decision.
// ----------------------------------------------------------------------------
module bptm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bptm_pkg::tok_t  tok_in,
	output bptm_pkg::tok_t  tok_out,
	input  bptm_pkg::cmt_t  cmt
);

	localparam logic [bptm_pkg::IDX_W-1:0] MY_IDX = bptm_pkg::IDX_W'(CELL_IDX);

	logic                         valid_q;
	logic [bptm_pkg::FILE_W-1:0]  file_q;
	logic [bptm_pkg::BLOCK_W-1:0] block_q;
	logic [bptm_pkg::USES_W-1:0]  uses_q;
	logic [bptm_pkg::IDX_W-1:0]   rank_q;
	bptm_pkg::tok_t               tok_n;
	logic                         tag_eq;
	logic                         is_clear;

	assign tag_eq   = valid_q && (file_q == tok_in.file) && (block_q == tok_in.block);
	assign is_clear = (cmt.func == bptm_pkg::FUNC_CLEAR);

	always_comb begin
		tok_n = tok_in;
		if (tag_eq && (!tok_in.m_found || rank_q < tok_in.m_rank)) begin
			tok_n.m_found = 1'b1;
			tok_n.m_idx   = MY_IDX;
			tok_n.m_rank  = rank_q;
		end
		if (!valid_q && !tok_in.f_found) begin
			tok_n.f_found = 1'b1;
			tok_n.f_idx   = MY_IDX;
		end
		if (valid_q && (!tok_in.v_found || uses_q < tok_in.v_uses ||
				(uses_q == tok_in.v_uses && rank_q < tok_in.v_rank))) begin
			tok_n.v_found = 1'b1;
			tok_n.v_idx   = MY_IDX;
			tok_n.v_rank  = rank_q;
			tok_n.v_uses  = uses_q;
			tok_n.v_file  = file_q;
			tok_n.v_block = block_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= tok_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			file_q  <= '0;
			block_q <= '0;
			uses_q  <= '0;
			rank_q  <= '0;
		end else if (cmt.valid) begin
			if (cmt.idx == MY_IDX) begin
				if (cmt.hit) begin
					if (is_clear) begin
						file_q  <= '0;
						block_q <= '0;
						uses_q  <= '0;
					end else if (uses_q != '1) begin
						uses_q <= uses_q + 1'b1;
					end
				end else begin
					valid_q <= 1'b1;
					rank_q  <= '0;
					uses_q  <= '0;
					file_q  <= is_clear ? '0 : cmt.file;
					block_q <= is_clear ? '0 : cmt.block;
				end
			end else if (!cmt.hit && valid_q && ({1'b0, rank_q} < cmt.cut)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule

/* src/buffer_pool_tag_manager.sv */
// ----------------------------------------------------------------------------
// Buffer pool tag manager
// Fully associative tag store with least-frequently-used replacement,
// built as a row of slot cells that a lookup item walks through.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (s_*) takes one item: s_tuser is the function
//   (0 = get block, 1 = clear block) and s_tdata carries the tag. The result
//   channel (m_*) returns exactly one item per request.
//   An accepted request is registered, then walks the row of SLOTS cells,
//   one cell per cycle. Each cell folds its slot into the item: newest
//   matching tag, lowest free slot, and the replacement candidate (fewest
//   uses, newest install on a tie). When the item leaves the last cell the
//   decision is made and broadcast to all cells in the same cycle, which
//   update tags, use counts and install ranks.
//   The next request is taken only after the previous lookup has left the
//   last cell, so lookups never overlap in the cell row.
//   A result waits in the output register when the receiver stalls; a
//   second result can park in a skid register, so the next request is
//   still accepted while one result waits. With both full, s_tready is low.
//   Reset empties every slot (no valid tags, zero uses) and drops any
//   request or result in flight.
// ----------------------------------------------------------------------------
module buffer_pool_tag_manager #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // file_id[15:0], block_num[39:16]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit[0], slot[4:1], fetch[5], evicted[6], evicted_file[22:7],
	// evicted_block[46:23], write_back[47]
	output logic [47:0] m_tdata
);

	localparam int CW = bptm_pkg::CUT_W;

	bptm_pkg::tok_t tok_chain [0:SLOTS];
	bptm_pkg::tok_t req_q;
	bptm_pkg::tok_t req_n;
	bptm_pkg::tok_t tok_e;
	bptm_pkg::cmt_t cmt;
	logic [SLOTS:0] tok_valid_vec;

	logic                                busy_q;
	logic                                skid_v_q;
	logic [bptm_pkg::OUT_DATA_W-1:0]     out_q;
	logic [bptm_pkg::OUT_DATA_W-1:0]     skid_q;
	logic                                m_tvalid_q;
	logic [bptm_pkg::OUT_DATA_W-1:0]     res;
	logic                                accept;
	logic                                pop;
	logic                                evict;

	// A new request is taken only when no lookup is walking the row and the
	// skid register has room for its result.
	assign s_tready = !busy_q && !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign pop      = m_tvalid_q && m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// Input register: a fresh lookup item with nothing found yet.
	always_comb begin
		req_n       = '0;
		req_n.valid = accept;
		req_n.func  = s_tuser[0];
		req_n.file  = s_tdata[bptm_pkg::FILE_W-1:0];
		req_n.block = s_tdata[bptm_pkg::IN_DATA_W-1:bptm_pkg::FILE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else begin
			req_q <= req_n;
		end
	end

	assign tok_chain[0] = req_q;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			bptm_cell #(
				.CELL_IDX(gi)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (tok_chain[gi]),
				.tok_out(tok_chain[gi+1]),
				.cmt    (cmt)
			);
		end
		for (gi = 0; gi <= SLOTS; gi++) begin : g_vld
			assign tok_valid_vec[gi] = tok_chain[gi].valid;
		end
	endgenerate

	assign tok_e = tok_chain[SLOTS];

	// Decision when the lookup leaves the last cell. A hit keeps its slot;
	// a miss takes the lowest free slot, or else evicts the candidate and
	// ages only the slots that were newer than it.
	always_comb begin
		cmt       = '0;
		cmt.valid = tok_e.valid;
		cmt.hit   = tok_e.m_found;
		cmt.func  = tok_e.func;
		cmt.file  = tok_e.file;
		cmt.block = tok_e.block;
		evict     = 1'b0;
		if (tok_e.m_found) begin
			cmt.idx = tok_e.m_idx;
		end else if (tok_e.f_found) begin
			cmt.idx = tok_e.f_idx;
			cmt.cut = CW'(SLOTS);
		end else begin
			evict   = 1'b1;
			cmt.idx = tok_e.v_found ? tok_e.v_idx : '0;
			cmt.cut = {1'b0, tok_e.v_rank};
		end
	end

	assign res = {tok_e.func == bptm_pkg::FUNC_CLEAR,
		evict ? tok_e.v_block : {bptm_pkg::BLOCK_W{1'b0}},
		evict ? tok_e.v_file : {bptm_pkg::FILE_W{1'b0}},
		evict,
		!tok_e.m_found,
		cmt.idx[bptm_pkg::SLOT_W-1:0],
		tok_e.m_found};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (tok_e.valid) begin
			busy_q <= 1'b0;
		end
	end

	// Output register plus one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			skid_v_q   <= 1'b0;
			out_q      <= '0;
			skid_q     <= '0;
		end else begin
			if (tok_e.valid) begin
				if (!m_tvalid_q || pop) begin
					out_q      <= res;
					m_tvalid_q <= 1'b1;
				end else begin
					skid_q   <= res;
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_v_q) begin
					out_q    <= skid_q;
					skid_v_q <= 1'b0;
				end else begin
					m_tvalid_q <= 1'b0;
				end
			end
		end
	end

	// Only one lookup walks the cell row at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid_vec))
		else $error("more than one lookup in the cell row");

	// A lookup leaving the row always belongs to an accepted, unfinished request.
	a_tok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_e.valid |-> busy_q)
		else $error("lookup left the row with no request pending");

	// The skid entry is only used behind a waiting output.
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> m_tvalid_q)
		else $error("skid entry holds a result while the output is empty");

	// A finished lookup never finds both result registers taken.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tok_e.valid |-> !skid_v_q)
		else $error("result arrived with no room to hold it");

endmodule

/* sim/bptm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool tag manager checker
// Watches both channels of the tag manager. Every accepted request is run
// through a local copy of the slot table to predict its result item, and
// every accepted result item is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bptm_checker #(
	parameter int   SLOTS      = 16,
	parameter logic CLEAR_FUNC = bptm_pkg::FUNC_CLEAR
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // file_id[15:0], block_num[39:16]
	input  logic [0:0]  s_tuser,   // func[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	// hit[0], slot[4:1], fetch[5], evicted[6], evicted_file[22:7],
	// evicted_block[46:23], write_back[47]
	input  logic [47:0] m_tdata,
	output int          fail_count,
	output int          outstanding,
	output int          request_count,
	output int          hit_count,
	output int          evict_count,
	output int          clear_count
);

	// Laid out so that the struct matches m_tdata bit for bit.
	typedef struct packed {
		logic                         write_back;
		logic [bptm_pkg::BLOCK_W-1:0] evicted_block;
		logic [bptm_pkg::FILE_W-1:0]  evicted_file;
		logic                         evicted;
		logic                         fetch;
		logic [3:0]                   slot;
		logic                         hit;
	} lookup_result_t;

	lookup_result_t     expected_q[$];

	logic [bptm_pkg::FILE_W-1:0]  tag_file  [SLOTS];
	logic [bptm_pkg::BLOCK_W-1:0] tag_block [SLOTS];
	logic [15:0]                  use_count [SLOTS];
	logic                         occupied  [SLOTS];
	int                           age_rank  [SLOTS];  // 0 = most recently installed

	int fails, requests, hits, evicts, clears;

	task automatic check_field(input string name, input logic [23:0] want_v,
		input logic [23:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : observe
		lookup_result_t               want, got;
		int                           spot, cut;
		logic [bptm_pkg::FILE_W-1:0]  rq_file;
		logic [bptm_pkg::BLOCK_W-1:0] rq_block;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tag_file[i]  = '0;
				tag_block[i] = '0;
				use_count[i] = '0;
				occupied[i]  = 1'b0;
				age_rank[i]  = 0;
			end
			expected_q.delete();
			fails    = 0;
			requests = 0;
			hits     = 0;
			evicts   = 0;
			clears   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_q.size() == 0) begin
					$display("%0t: result item %0h arrived with none expected",
						$time, m_tdata);
					fails++;
				end else begin
					want = expected_q.pop_front();
					check_field("hit", 24'(want.hit), 24'(got.hit));
					check_field("slot", 24'(want.slot), 24'(got.slot));
					check_field("fetch", 24'(want.fetch), 24'(got.fetch));
					check_field("evicted", 24'(want.evicted), 24'(got.evicted));
					check_field("evicted_file", 24'(want.evicted_file),
						24'(got.evicted_file));
					check_field("evicted_block", want.evicted_block, got.evicted_block);
					check_field("write_back", 24'(want.write_back), 24'(got.write_back));
				end
			end

			if (s_tvalid && s_tready) begin
				rq_file  = s_tdata[15:0];
				rq_block = s_tdata[39:16];
				want     = '0;
				requests++;

				// Newest-installed slot holding the tag wins among duplicates.
				spot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (occupied[i] && tag_file[i] == rq_file && tag_block[i] == rq_block)
						if (spot < 0 || age_rank[i] < age_rank[spot])
							spot = i;

				if (spot >= 0) begin
					want.hit = 1'b1;
					hits++;
					if (use_count[spot] != 16'hFFFF)
						use_count[spot]++;
				end else begin
					want.fetch = 1'b1;
					for (int i = 0; i < SLOTS; i++)
						if (!occupied[i] && spot < 0)
							spot = i;
					if (spot >= 0) begin
						cut            = SLOTS;
						occupied[spot] = 1'b1;
					end else begin
						// Fewest uses, newest install on a tie.
						for (int i = 0; i < SLOTS; i++)
							if (spot < 0 || use_count[i] < use_count[spot] ||
								(use_count[i] == use_count[spot] &&
								 age_rank[i] < age_rank[spot]))
								spot = i;
						want.evicted       = 1'b1;
						want.evicted_file  = tag_file[spot];
						want.evicted_block = tag_block[spot];
						cut                = age_rank[spot];
						evicts++;
					end
					for (int i = 0; i < SLOTS; i++)
						if (i != spot && occupied[i] && age_rank[i] < cut)
							age_rank[i]++;
					tag_file[spot]  = rq_file;
					tag_block[spot] = rq_block;
					use_count[spot] = '0;
					age_rank[spot]  = 0;
				end

				if (s_tuser[0] == CLEAR_FUNC) begin
					tag_file[spot]  = '0;
					tag_block[spot] = '0;
					use_count[spot] = '0;
					want.write_back = 1'b1;
					clears++;
				end
				want.slot = spot[3:0];
				expected_q.push_back(want);
			end
		end
		fail_count    <= fails;
		outstanding   <= expected_q.size();
		request_count <= requests;
		hit_count     <= hits;
		evict_count   <= evicts;
		clear_count   <= clears;
	end

endmodule

/* sim/buffer_pool_tag_manager_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool tag manager testbench
// Drives requests into the tag manager in random bursts, stalls the result
// side on its own pattern, and lets the checker predict and compare every
// result item. A directed opening walks the corner cases of the slot table,
// then a long random phase works a skewed set of hot tags.
// ----------------------------------------------------------------------------
module buffer_pool_tag_manager_tb;

	localparam int   SLOTS         = 16;
	localparam logic FUNC_GET      = bptm_pkg::FUNC_GET;
	localparam logic FUNC_CLEAR    = bptm_pkg::FUNC_CLEAR;
	localparam int   RANDOM_ITEMS  = 750;
	localparam int   HOT_TAGS      = 24;   // more than SLOTS, so evictions happen
	localparam int   HOLD_CYCLES   = 400;  // long receiver hold-off
	localparam int   DRAIN_CYCLES  = 4 * (SLOTS + 2);

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // file_id[15:0], block_num[39:16]
	logic [0:0]  s_tuser  = '0;   // func[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// hit[0], slot[4:1], fetch[5], evicted[6], evicted_file[22:7],
	// evicted_block[46:23], write_back[47]
	logic [47:0] m_tdata;

	int fail_count, outstanding, request_count, hit_count, evict_count, clear_count;

	// Hot tag set for the random phase; entries are refreshed now and then so
	// old tags age out of the pool.
	logic [15:0] hot_file  [HOT_TAGS];
	logic [23:0] hot_block [HOT_TAGS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	buffer_pool_tag_manager #(.SLOTS(SLOTS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bptm_checker #(.SLOTS(SLOTS), .CLEAR_FUNC(FUNC_CLEAR)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.request_count (request_count),
		.hit_count     (hit_count),
		.evict_count   (evict_count),
		.clear_count   (clear_count)
	);

	// Offers one request from a falling edge and holds it until the rising
	// edge that accepts it. Valid is left high afterwards; the caller lowers
	// it only when a gap begins, so back-to-back items never glitch it.
	task automatic send_request(input logic fn, input logic [15:0] file_id,
		input logic [23:0] block_num);
		s_tuser  = fn;
		s_tdata  = {block_num, file_id};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Receiver: runs in segments, each with its own stall pattern. A long
	// hold-off comes before the thirteenth segment, which lets the
	// output and skid registers fill so that the block pushes back on the
	// request side while the sender keeps offering items.
	initial begin : receiver
		int seg, mode, seg_len;
		seg = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (seg == 12) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(20, 120);
			for (int c = 0; c < seg_len; c++) begin
				case (mode)
					0: begin
						m_tready = 1'b1;
					end
					1: begin
						m_tready = ($urandom_range(0, 1) == 1);
					end
					2: begin
						m_tready = ($urandom_range(0, 4) == 0);
					end
					default: begin
						m_tready = ((c % 4) == 0);
					end
				endcase
				@(negedge clk);
			end
			seg++;
		end
	end

	initial begin : sender
		int          sent, burst_len, gap, pick;
		logic [15:0] rq_file;
		logic [23:0] rq_block;
		logic        rq_func;

		for (int k = 0; k < HOT_TAGS; k++) begin
			hot_file[k]  = 16'($urandom_range(0, 65535));
			hot_block[k] = 24'($urandom_range(0, 16777215));
		end
		// Keep the empty tag and the all-ones tag among the hot entries.
		hot_file[0]  = 16'h0000;
		hot_block[0] = 24'h000000;
		hot_file[1]  = 16'hFFFF;
		hot_block[1] = 24'hFFFFFF;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed opening. The empty tag is requested on an empty pool, hit,
		// then duplicated by clears so that the newest copy has to win.
		send_request(FUNC_GET, 16'h0000, 24'h000000);
		send_request(FUNC_GET, 16'h0000, 24'h000000);
		send_request(FUNC_GET, 16'hFFFF, 24'hFFFFFF);
		send_request(FUNC_CLEAR, 16'hFFFF, 24'hFFFFFF);
		send_request(FUNC_GET, 16'h0000, 24'h000000);
		// A clear that misses installs the tag first and then empties it.
		send_request(FUNC_CLEAR, 16'h0001, 24'h000001);
		send_request(FUNC_GET, 16'h0000, 24'h000000);
		// Fill the rest of the pool with unused tags; free slots go lowest
		// first.
		for (int i = 3; i < SLOTS; i++)
			send_request(FUNC_GET, 16'(i), 24'h800000 | 24'(i));
		// Full pool: many slots tie at zero uses, so the newest goes first.
		send_request(FUNC_GET, 16'hFFFF, 24'h000000);
		send_request(FUNC_GET, 16'h0000, 24'hFFFFFF);
		send_request(FUNC_CLEAR, 16'hFFFF, 24'h000000);
		// A clear that misses on a full pool evicts as a get would.
		send_request(FUNC_CLEAR, 16'h5A5A, 24'hA5A5A5);
		send_request(FUNC_GET, 16'hA5A5, 24'h5A5A5A);
		s_tvalid = 1'b0;
		repeat ($urandom_range(5, 30)) @(negedge clk);

		// Random phase: mostly a skewed pick from the hot set so that use
		// counts spread out, with some fresh tags, empty tags and extremes.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 16);
			for (int j = 0; j < burst_len && sent < RANDOM_ITEMS; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					pick     = $urandom_range(0, $urandom_range(0, HOT_TAGS - 1));
					rq_file  = hot_file[pick];
					rq_block = hot_block[pick];
				end else if (pick < 82) begin
					rq_file  = 16'($urandom_range(0, 65535));
					rq_block = 24'($urandom_range(0, 16777215));
				end else if (pick < 90) begin
					rq_file  = 16'h0000;
					rq_block = 24'h000000;
				end else begin
					rq_file  = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
					rq_block = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'h000000;
				end
				rq_func = ($urandom_range(0, 99) < 12) ? FUNC_CLEAR : FUNC_GET;
				send_request(rq_func, rq_file, rq_block);
				sent++;
				if ((sent % 64) == 0) begin
					pick            = $urandom_range(2, HOT_TAGS - 1);
					hot_file[pick]  = 16'($urandom_range(0, 65535));
					hot_block[pick] = 24'($urandom_range(0, 16777215));
				end
			end
			// Every few bursts run straight on with no gap at all.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid = 1'b0;

		// Wait for every predicted result, then a little longer so that a
		// stray extra result would still be caught.
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d requests: %0d hits, %0d evictions, %0d clears,",
			request_count, hit_count, evict_count, clear_count);
		$display("with bursty input, varied output stalls and one long output hold-off.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d results still expected", outstanding);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
